// File: design/sorted_disk_request_queue_defines.svh
// assertion macros used by the checker file
`ifndef SORTED_DISK_REQUEST_QUEUE_DEFINES_SVH
`define SORTED_DISK_REQUEST_QUEUE_DEFINES_SVH

// assertion on an explicit clock and active-low reset
`define SDRQ_CHECK_ON(label, clock, rstn, prop, msg) \
	label: assert property (@(posedge clock) disable iff (!rstn) prop) else $error(msg);

// assertion on the block clock and reset
`define SDRQ_CHECK(label, prop, msg) \
	`SDRQ_CHECK_ON(label, clk, arst_n, prop, msg)

`endif

// File: design/sdrq_pkg.sv
package sdrq_pkg;

	localparam int TAG_W    = 8;
	localparam int SECTOR_W = 32;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 3;
	localparam int OCC_W    = 5;

	// operation codes
	localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE   = 2'd1;
	localparam logic [OP_W-1:0] OP_GET_NEXT = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DUP      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]     opcode;
		logic [TAG_W-1:0]    req_tag;
		logic [SECTOR_W-1:0] start_sector;
		logic                is_plug;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [TAG_W-1:0]    out_tag;
		logic [SECTOR_W-1:0] out_sector;
		logic                out_plug;
		logic [OCC_W-1:0]    occupancy;
	} rsp_t;

	// one stored queue entry
	typedef struct packed {
		logic [TAG_W-1:0]    tag;
		logic [SECTOR_W-1:0] sector;
		logic                plug;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic decide;
		logic shift;
		logic place;
		logic emit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
		logic shift_done;
		logic place_pend;
		logic out_busy;
	} dp_sts_t;

endpackage

// File: design/sdrq_ram.sv
module sdrq_ram #(
	parameter int WIDTH = 41,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// File: design/sdrq_ctrl.sv
module sdrq_ctrl
	import sdrq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  dp_sts_t   sts,
	output ctrl_cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_SHIFT  = 3'd3;
	localparam logic [2:0] S_PLACE  = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_nxt = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_nxt  = S_SHIFT;
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				if (sts.shift_done) begin
					state_nxt = sts.place_pend ? S_PLACE : S_DONE;
				end
			end
			S_PLACE: begin
				cmd.place = 1'b1;
				state_nxt = S_DONE;
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.emit  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// File: design/sdrq_dp.sv
module sdrq_dp
	import sdrq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  req_t      req,
	input  ctrl_cmd_t cmd,
	output dp_sts_t   sts,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_t      rsp
);

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

	// architectural state
	logic [CW-1:0]    count_q;
	logic             barrier_valid_q;
	logic [TAG_W-1:0] barrier_tag_q;
	logic             current_valid_q;
	logic [TAG_W-1:0] current_tag_q;

	req_t req_q;

	// scan
	logic [CW-1:0] scan_idx_q;
	logic          rd_valid_s1;
	logic [IW-1:0] idx_s1;

	// scan results
	logic             hit_found_q;
	logic [IW-1:0]    hit_pos_q;
	logic             next_seen_q;
	logic [TAG_W-1:0] next_tag_q;
	logic             bar_found_q;
	logic             jb_found_q;
	logic [IW-1:0]    jb_pos_q;
	logic             j0_found_q;
	logic [IW-1:0]    j0_pos_q;
	logic             lt_head_q;
	entry_t           head_q;
	logic             cur_found_q;
	logic             cur_at_head_q;
	entry_t           cur_q;

	// move plan
	logic          place_pend_q;
	logic [IW-1:0] pos_q;
	logic [CW-1:0] rem_q;
	logic [IW-1:0] src_q;
	logic          wr_pend_s1;
	logic [IW-1:0] wr_addr_s1;

	logic [STATUS_W-1:0] res_status_q;
	entry_t              res_entry_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	// ram port
	logic [ENTRY_W-1:0] ram_rdata;
	logic               ram_wr_en;
	logic [IW-1:0]      ram_wr_addr;
	logic [ENTRY_W-1:0] ram_wr_data;
	logic [IW-1:0]      ram_rd_addr;

	entry_t e;
	entry_t new_entry;
	logic   scan_issue;
	logic   shift_issue;
	logic   lt;
	logic   idx_is_head;
	logic   hit_now;
	logic   next_now;
	logic   bar_now;
	logic   jb_now;
	logic   j0_now;
	logic   head_now;
	logic   cur_now;

	// decision
	logic                at_head;
	logic [IW-1:0]       ins_pos;
	logic                use_head;
	logic [STATUS_W-1:0] d_status;
	logic                d_place;
	logic [IW-1:0]       d_pos;
	logic [CW-1:0]       d_rem;
	logic [IW-1:0]       d_src;
	entry_t              d_entry;
	logic [CW-1:0]       d_count;
	logic                d_bv;
	logic [TAG_W-1:0]    d_bt;
	logic                d_cv;
	logic [TAG_W-1:0]    d_ct;

	sdrq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rdata)
	);

	assign scan_issue  = cmd.scan && (scan_idx_q < count_q);
	assign shift_issue = cmd.shift && (rem_q != '0);
	assign ram_rd_addr = cmd.shift ? src_q : scan_idx_q[IW-1:0];

	assign new_entry = '{tag: req_q.req_tag, sector: req_q.start_sector, plug: req_q.is_plug};

	assign ram_wr_en   = wr_pend_s1 || cmd.place;
	assign ram_wr_addr = wr_pend_s1 ? wr_addr_s1 : pos_q;
	assign ram_wr_data = wr_pend_s1 ? ram_rdata : new_entry;

	// per-entry compares on the scan read data
	assign e           = entry_t'(ram_rdata);
	assign lt          = req_q.start_sector < e.sector;
	assign idx_is_head = (idx_s1 == '0);
	assign hit_now     = rd_valid_s1 && !hit_found_q && (e.tag == req_q.req_tag);
	assign next_now    = rd_valid_s1 && hit_found_q && !next_seen_q;
	assign bar_now     = rd_valid_s1 && !bar_found_q && barrier_valid_q
	                     && (e.tag == barrier_tag_q);
	assign jb_now      = rd_valid_s1 && bar_found_q && !jb_found_q && lt;
	assign j0_now      = rd_valid_s1 && !idx_is_head && !j0_found_q && lt;
	assign head_now    = rd_valid_s1 && idx_is_head;
	assign cur_now     = rd_valid_s1 && !cur_found_q && current_valid_q
	                     && (e.tag == current_tag_q);

	// insert position
	assign at_head = (count_q == '0) || lt_head_q;

	always_comb begin
		priority if (at_head) begin
			ins_pos = '0;
		end else if (req_q.is_plug) begin
			ins_pos = count_q[IW-1:0];
		end else if (bar_found_q) begin
			ins_pos = jb_found_q ? jb_pos_q : count_q[IW-1:0];
		end else begin
			ins_pos = j0_found_q ? j0_pos_q : count_q[IW-1:0];
		end
	end

	assign use_head = !cur_found_q || (cur_q.plug && !cur_at_head_q);

	always_comb begin
		d_status = ST_OK;
		d_place  = 1'b0;
		d_pos    = ins_pos;
		d_rem    = '0;
		d_src    = IW'(count_q - CW'(1));
		d_entry  = '0;
		d_count  = count_q;
		d_bv     = barrier_valid_q;
		d_bt     = barrier_tag_q;
		d_cv     = current_valid_q;
		d_ct     = current_tag_q;
		unique case (req_q.opcode)
			OP_INSERT: begin
				priority if (hit_found_q) begin
					d_status = ST_DUP;
				end else if (count_q == FULL_COUNT) begin
					d_status = ST_FULL;
				end else begin
					d_place = 1'b1;
					d_rem   = count_q - CW'(ins_pos);
					d_count = count_q + CW'(1);
					if (!at_head && req_q.is_plug) begin
						d_bv = 1'b1;
						d_bt = req_q.req_tag;
					end
				end
			end
			OP_REMOVE: begin
				priority if (count_q == '0) begin
					d_status = ST_EMPTY;
				end else if (!hit_found_q) begin
					d_status = ST_NOTFOUND;
				end else begin
					d_pos   = hit_pos_q;
					d_rem   = count_q - CW'(hit_pos_q) - CW'(1);
					d_src   = hit_pos_q + IW'(1);
					d_count = count_q - CW'(1);
					if (current_valid_q && (current_tag_q == req_q.req_tag)) begin
						if (next_seen_q) begin
							d_ct = next_tag_q;
						end else begin
							d_cv = 1'b0;
						end
					end
					if (barrier_valid_q && (barrier_tag_q == req_q.req_tag)) begin
						d_bv = 1'b0;
					end
				end
			end
			OP_GET_NEXT: begin
				if (count_q == '0) begin
					d_status = ST_EMPTY;
				end else begin
					d_entry = use_head ? head_q : cur_q;
					d_cv    = 1'b1;
					d_ct    = d_entry.tag;
				end
			end
			default: begin
			end
		endcase
	end

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q         <= '0;
			barrier_valid_q <= 1'b0;
			barrier_tag_q   <= '0;
			current_valid_q <= 1'b0;
			current_tag_q   <= '0;
			scan_idx_q      <= '0;
			rd_valid_s1     <= 1'b0;
			hit_found_q     <= 1'b0;
			next_seen_q     <= 1'b0;
			bar_found_q     <= 1'b0;
			jb_found_q      <= 1'b0;
			j0_found_q      <= 1'b0;
			lt_head_q       <= 1'b0;
			cur_found_q     <= 1'b0;
			place_pend_q    <= 1'b0;
			rem_q           <= '0;
			wr_pend_s1      <= 1'b0;
			rsp_valid_q     <= 1'b0;
		end else begin
			rd_valid_s1 <= scan_issue;
			wr_pend_s1  <= shift_issue;
			if (cmd.load) begin
				scan_idx_q  <= '0;
				hit_found_q <= 1'b0;
				next_seen_q <= 1'b0;
				bar_found_q <= 1'b0;
				jb_found_q  <= 1'b0;
				j0_found_q  <= 1'b0;
				lt_head_q   <= 1'b0;
				cur_found_q <= 1'b0;
			end else begin
				if (scan_issue) begin
					scan_idx_q <= scan_idx_q + CW'(1);
				end
				if (hit_now) hit_found_q <= 1'b1;
				if (next_now) next_seen_q <= 1'b1;
				if (bar_now) bar_found_q <= 1'b1;
				if (jb_now) jb_found_q <= 1'b1;
				if (j0_now) j0_found_q <= 1'b1;
				if (head_now) lt_head_q <= lt;
				if (cur_now) cur_found_q <= 1'b1;
			end
			if (cmd.decide) begin
				count_q         <= d_count;
				barrier_valid_q <= d_bv;
				barrier_tag_q   <= d_bt;
				current_valid_q <= d_cv;
				current_tag_q   <= d_ct;
				place_pend_q    <= d_place;
				rem_q           <= d_rem;
			end else if (shift_issue) begin
				rem_q <= rem_q - CW'(1);
			end
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (scan_issue) begin
			idx_s1 <= scan_idx_q[IW-1:0];
		end
		if (hit_now) hit_pos_q <= idx_s1;
		if (next_now) next_tag_q <= e.tag;
		if (jb_now) jb_pos_q <= idx_s1;
		if (j0_now) j0_pos_q <= idx_s1;
		if (head_now) head_q <= e;
		if (cur_now) begin
			cur_q         <= e;
			cur_at_head_q <= idx_is_head;
		end
		if (cmd.decide) begin
			pos_q        <= d_pos;
			src_q        <= d_src;
			res_status_q <= d_status;
			res_entry_q  <= d_entry;
		end else if (shift_issue) begin
			src_q <= place_pend_q ? src_q - IW'(1) : src_q + IW'(1);
		end
		if (shift_issue) begin
			wr_addr_s1 <= place_pend_q ? src_q + IW'(1) : src_q - IW'(1);
		end
		if (cmd.emit) begin
			rsp_q <= '{status: res_status_q, out_tag: res_entry_q.tag,
			           out_sector: res_entry_q.sector, out_plug: res_entry_q.plug,
			           occupancy: OCC_W'(count_q)};
		end
	end

	assign sts.scan_done  = (scan_idx_q == count_q) && !rd_valid_s1;
	assign sts.shift_done = (rem_q == '0) && !wr_pend_s1;
	assign sts.place_pend = place_pend_q;
	assign sts.out_busy   = rsp_valid_q && !rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: design/sorted_disk_request_queue.sv
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | req_t: opcode, req_tag, start_sector, is_plug
// rsp     | out       | rsp_valid / rsp_ready | rsp_t: status, out_tag, out_sector,
//         |           |                       |        out_plug, occupancy
//
// one item at a time; an item takes longer the more entries are held, longest for an insert
// near the head, as this is set by the single ram read port
// (one entry per cycle for the scan and again for the move)
// reset clears the count, barrier and current pointer; the ram needs no clearing
// a waiting result sits in the output register while the next item is worked on
// the result of the next item stalls only if the previous one is still not taken
module sorted_disk_request_queue
	import sdrq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	// controller steps: accept, scan, decide, move, place, hand over
	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	sdrq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: entry ram, scan trackers, move pointers, output register
	sdrq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// File: design/sdrq_checker.sv
`include "sorted_disk_request_queue_defines.svh"

module sdrq_checker
	import sdrq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	`SDRQ_CHECK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "result changed while stalled")
	`SDRQ_CHECK(a_one_at_a_time, req_valid && req_ready |=> !req_ready, "item accepted while busy")
	`SDRQ_CHECK(a_fields_clear, rsp_valid && rsp.status != ST_OK |-> rsp.out_tag == '0 && rsp.out_sector == '0 && !rsp.out_plug, "entry fields set on a failed item")
	`SDRQ_CHECK(a_full_occ, rsp_valid && rsp.status == ST_FULL |-> rsp.occupancy == OCC_W'(QUEUE_DEPTH), "full status with room left")
	`SDRQ_CHECK(a_empty_occ, rsp_valid && rsp.status == ST_EMPTY |-> rsp.occupancy == '0, "empty status with entries held")

endmodule

bind sorted_disk_request_queue sdrq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_sdrq_checker (.*);

// File: tb/sv/tb_sorted_disk_request_queue.sv
`timescale 1ns / 1ps

module tb_sorted_disk_request_queue;
	import sdrq_pkg::*;

	localparam int QUEUE_DEPTH = 16;
	localparam int RANDOM_BLOCKS = 25;
	localparam int BLOCK_ITEMS = 73;
	// spare opcode, the block treats it as a no-op
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// how a block of random items leans: towards a full queue, an empty one, or neither
	typedef enum int {LOADING, DRAINING, STEADY} load_e;

	// one line of the directed table: the item and, where obvious, its result
	typedef struct packed {
		req_t item;
		logic known;
		rsp_t want;
	} dir_row_t;

	localparam rsp_t NO_RSP = '0;

	localparam dir_row_t DIRECTED [25] = '{
		// empty queue after reset
		'{'{OP_GET_NEXT, 8'h00, 32'h0000_0000, 1'b0}, 1'b1, '{ST_EMPTY, 8'h00, 32'h0, 1'b0, 5'd0}},
		'{'{OP_REMOVE, 8'h5a, 32'h0000_0000, 1'b0}, 1'b1, '{ST_EMPTY, 8'h00, 32'h0, 1'b0, 5'd0}},
		// spare opcode with every payload bit set
		'{'{OP_UNUSED, 8'hff, 32'hffff_ffff, 1'b1}, 1'b1, '{ST_OK, 8'h00, 32'h0, 1'b0, 5'd0}},
		// top tag and sector, then a lower sector that takes the head
		'{'{OP_INSERT, 8'hff, 32'hffff_ffff, 1'b0}, 1'b1, '{ST_OK, 8'h00, 32'h0, 1'b0, 5'd1}},
		'{'{OP_INSERT, 8'h00, 32'h0000_0001, 1'b0}, 1'b1, '{ST_OK, 8'h00, 32'h0, 1'b0, 5'd2}},
		// duplicate tag, absent tag
		'{'{OP_INSERT, 8'hff, 32'h0000_0000, 1'b1}, 1'b1, '{ST_DUP, 8'h00, 32'h0, 1'b0, 5'd2}},
		'{'{OP_REMOVE, 8'h55, 32'h0000_0000, 1'b0}, 1'b1, '{ST_NOTFOUND, 8'h00, 32'h0, 1'b0, 5'd2}},
		// no current entry yet, so the head comes back
		'{'{OP_GET_NEXT, 8'h00, 32'h0000_0000, 1'b0}, 1'b1, '{ST_OK, 8'h00, 32'h1, 1'b0, 5'd2}},
		// plug at the tail becomes the barrier, others sort in behind it or take the head
		'{'{OP_INSERT, 8'h10, 32'h8000_0000, 1'b1}, 1'b0, NO_RSP},
		'{'{OP_INSERT, 8'h11, 32'h7000_0000, 1'b0}, 1'b0, NO_RSP},
		'{'{OP_INSERT, 8'h12, 32'h7000_0000, 1'b0}, 1'b0, NO_RSP},
		'{'{OP_INSERT, 8'h13, 32'h6000_0000, 1'b0}, 1'b0, NO_RSP},
		'{'{OP_INSERT, 8'h20, 32'h0000_0000, 1'b0}, 1'b0, NO_RSP},
		// drop the entry ahead of the plug, then the current one, so current lands on the plug
		'{'{OP_REMOVE, 8'hff, 32'h0000_0000, 1'b0}, 1'b0, NO_RSP},
		'{'{OP_REMOVE, 8'h00, 32'h0000_0000, 1'b0}, 1'b0, NO_RSP},
		// plug away from the head falls back to the head
		'{'{OP_GET_NEXT, 8'h00, 32'h0000_0000, 1'b0}, 1'b0, NO_RSP},
		// removing the barrier forgets it
		'{'{OP_REMOVE, 8'h10, 32'h0000_0000, 1'b0}, 1'b0, NO_RSP},
		'{'{OP_INSERT, 8'h14, 32'h6000_0000, 1'b0}, 1'b0, NO_RSP},
		'{'{OP_INSERT, 8'h15, 32'h0000_0000, 1'b1}, 1'b0, NO_RSP},
		'{'{OP_REMOVE, 8'h12, 32'h0000_0000, 1'b0}, 1'b0, NO_RSP},
		'{'{OP_GET_NEXT, 8'h00, 32'h0000_0000, 1'b0}, 1'b0, NO_RSP},
		// current is removed and moves on to the next entry
		'{'{OP_REMOVE, 8'h20, 32'h0000_0000, 1'b0}, 1'b0, NO_RSP},
		'{'{OP_GET_NEXT, 8'h00, 32'h0000_0000, 1'b0}, 1'b0, NO_RSP},
		// plug with a lower sector goes to the head and is no barrier
		'{'{OP_INSERT, 8'h30, 32'h0000_0000, 1'b1}, 1'b0, NO_RSP},
		'{'{OP_GET_NEXT, 8'h00, 32'h0000_0000, 1'b0}, 1'b0, NO_RSP}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	// shadow of the queue contents, pointers and barrier
	entry_t held [QUEUE_DEPTH];
	int held_count;
	logic barrier_on;
	logic [TAG_W-1:0] barrier_id;
	logic cursor_on;
	logic [TAG_W-1:0] cursor_id;

	// results still owed by the block, oldest first
	rsp_t awaited_results [$];

	int mismatch_count;
	int items_sent;
	int results_seen;
	int status_seen [8];
	int peak_occupancy;

	// per-phase switches that turn off random idling on either side
	logic sender_calm;
	logic receiver_calm;

	sorted_disk_request_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #10 clk = ~clk;

	// position of a held tag, or -1
	function automatic int locate(logic [TAG_W-1:0] t);
		for (int i = 0; i < held_count; i++)
			if (held[i].tag == t)
				return i;
		return -1;
	endfunction

	// open a gap at pos and drop the entry in
	function automatic void insert_at(int pos, entry_t e);
		for (int i = held_count; i > pos; i--)
			held[i] = held[i - 1];
		held[pos] = e;
		held_count++;
	endfunction

	// apply one item to the shadow queue and work out the block's answer
	function automatic rsp_t apply_request(req_t r);
		rsp_t res;
		entry_t e;
		int p;
		int j;
		res = '0;
		res.status = ST_OK;
		e = '{r.req_tag, r.start_sector, r.is_plug};
		case (r.opcode)
			OP_INSERT: begin
				if (locate(r.req_tag) >= 0) begin
					// duplicate wins over full
					res.status = ST_DUP;
				end else if (held_count >= QUEUE_DEPTH) begin
					res.status = ST_FULL;
				end else if (held_count == 0 || r.start_sector < held[0].sector) begin
					insert_at(0, e);
				end else if (r.is_plug) begin
					insert_at(held_count, e);
					barrier_on = 1'b1;
					barrier_id = r.req_tag;
				end else begin
					// sorted search starts after the barrier, else after the head
					j = 0;
					if (barrier_on) begin
						p = locate(barrier_id);
						if (p >= 0)
							j = p;
					end
					j++;
					while (j < held_count && !(r.start_sector < held[j].sector))
						j++;
					insert_at(j, e);
				end
			end
			OP_REMOVE: begin
				if (held_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					p = locate(r.req_tag);
					if (p < 0) begin
						res.status = ST_NOTFOUND;
					end else begin
						if (cursor_on && cursor_id == r.req_tag) begin
							if (p + 1 < held_count)
								cursor_id = held[p + 1].tag;
							else
								cursor_on = 1'b0;
						end
						if (barrier_on && barrier_id == r.req_tag)
							barrier_on = 1'b0;
						for (int i = p; i + 1 < held_count; i++)
							held[i] = held[i + 1];
						held_count--;
					end
				end
			end
			OP_GET_NEXT: begin
				if (held_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					p = -1;
					if (cursor_on)
						p = locate(cursor_id);
					// stale pointer or a plug away from the head: back to the head
					if (p < 0 || (held[p].plug && p != 0))
						p = 0;
					cursor_on = 1'b1;
					cursor_id = held[p].tag;
					res.out_tag = held[p].tag;
					res.out_sector = held[p].sector;
					res.out_plug = held[p].plug;
				end
			end
			default: ;
		endcase
		res.occupancy = OCC_W'(held_count);
		return res;
	endfunction

	// random item shaped by the phase, with tags mostly from a small pool so that
	// duplicates, removes of held entries and a full queue come up often
	function automatic req_t next_request(load_e mode, logic [TAG_W-1:0] tag_base);
		req_t r;
		int roll;
		int ins_pct;
		int rem_pct;
		int pick;
		r.req_tag = TAG_W'($urandom);
		r.start_sector = $urandom;
		r.is_plug = ($urandom_range(0, 99) < 15);
		case (mode)
			LOADING: begin
				ins_pct = 60;
				rem_pct = 15;
			end
			DRAINING: begin
				ins_pct = 20;
				rem_pct = 55;
			end
			default: begin
				ins_pct = 40;
				rem_pct = 30;
			end
		endcase
		roll = $urandom_range(0, 99);
		if (roll < 3) begin
			r.opcode = OP_UNUSED;
		end else if (roll < 3 + ins_pct) begin
			r.opcode = OP_INSERT;
			pick = $urandom_range(0, 9);
			if (pick < 7)
				r.req_tag = tag_base ^ TAG_W'($urandom_range(0, 23));
			else if (pick < 9 && held_count > 0)
				r.req_tag = held[$urandom_range(0, held_count - 1)].tag;
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				// coarse sectors so that equal keys are common
				r.start_sector = {4'($urandom_range(0, 15)), 28'h0};
			end else if (pick < 7 && held_count > 0) begin
				r.start_sector = held[$urandom_range(0, held_count - 1)].sector;
			end else if (pick < 8) begin
				case ($urandom_range(0, 3))
					0: r.start_sector = 32'h0000_0000;
					1: r.start_sector = 32'h0000_0001;
					2: r.start_sector = 32'hffff_fffe;
					default: r.start_sector = 32'hffff_ffff;
				endcase
			end
		end else if (roll < 3 + ins_pct + rem_pct) begin
			r.opcode = OP_REMOVE;
			if (held_count > 0 && $urandom_range(0, 3) != 0)
				r.req_tag = held[$urandom_range(0, held_count - 1)].tag;
			else
				r.req_tag = tag_base ^ TAG_W'($urandom_range(0, 23));
		end else begin
			r.opcode = OP_GET_NEXT;
		end
		return r;
	endfunction

	// present one item after a random gap unless the sender is calm, wait for it to be taken, then book its result
	task automatic send_item(input req_t item, input logic known, input rsp_t want);
		int gap;
		rsp_t predicted;
		gap = sender_calm ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
		predicted = apply_request(item);
		awaited_results.push_back(known ? want : predicted);
		items_sent++;
	endtask

	// drop valid and hold off until every booked result has come back
	task automatic drain_results();
		req_valid <= 1'b0;
		do @(posedge clk); while (awaited_results.size() != 0);
	endtask

	// stimulus
	initial begin
		load_e mode;
		logic [TAG_W-1:0] tag_base;
		req_valid = 1'b0;
		req = '0;
		arst_n = 1'b0;
		held_count = 0;
		barrier_on = 1'b0;
		barrier_id = '0;
		cursor_on = 1'b0;
		cursor_id = '0;
		items_sent = 0;
		sender_calm = 1'b0;
		receiver_calm = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (DIRECTED[i])
			send_item(DIRECTED[i].item, DIRECTED[i].known, DIRECTED[i].want);
		drain_results();

		// random blocks, each with its own lean, tag pool and idling mix
		for (int b = 0; b < RANDOM_BLOCKS; b++) begin
			// every fifth block first waits until every booked result has come back
			if (b % 5 == 4)
				drain_results();
			mode = (b == 0) ? LOADING : load_e'($urandom_range(0, 2));
			tag_base = TAG_W'($urandom);
			sender_calm = ($urandom_range(0, 3) == 0);
			receiver_calm = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < BLOCK_ITEMS; k++)
				send_item(next_request(mode, tag_base), 1'b0, NO_RSP);
		end
		sender_calm = 1'b0;
		receiver_calm = 1'b0;

		drain_results();
		// the slowest item with a full queue is well under this
		repeat (60) @(posedge clk);

		$display("%0d items sent, %0d results checked: ok %0d, full %0d, not found %0d,",
			items_sent, results_seen, status_seen[ST_OK], status_seen[ST_FULL],
			status_seen[ST_NOTFOUND]);
		$display("duplicate %0d, empty %0d; peak occupancy %0d of %0d",
			status_seen[ST_DUP], status_seen[ST_EMPTY], peak_occupancy, QUEUE_DEPTH);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// result side: random stalls on ready, each taken item checked against the oldest booking
	initial begin
		int stall;
		rsp_t got;
		rsp_t want;
		rsp_ready = 1'b0;
		mismatch_count = 0;
		results_seen = 0;
		peak_occupancy = 0;
		foreach (status_seen[i])
			status_seen[i] = 0;
		wait (arst_n === 1'b1);
		forever begin
			stall = receiver_calm ? 0 : $urandom_range(0, 7);
			if (stall != 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			got = rsp;
			results_seen++;
			status_seen[got.status]++;
			if (int'(got.occupancy) > peak_occupancy)
				peak_occupancy = got.occupancy;
			if (awaited_results.size() == 0) begin
				$error("result with no item waiting: status %0d", got.status);
				mismatch_count++;
			end else begin
				want = awaited_results.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					mismatch_count++;
				end
				if (got.out_tag !== want.out_tag) begin
					$error("out_tag: expected %0h, got %0h", want.out_tag, got.out_tag);
					mismatch_count++;
				end
				if (got.out_sector !== want.out_sector) begin
					$error("out_sector: expected %0h, got %0h", want.out_sector,
						got.out_sector);
					mismatch_count++;
				end
				if (got.out_plug !== want.out_plug) begin
					$error("out_plug: expected %0b, got %0b", want.out_plug, got.out_plug);
					mismatch_count++;
				end
				if (got.occupancy !== want.occupancy) begin
					$error("occupancy: expected %0d, got %0d", want.occupancy,
						got.occupancy);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog, several times the slowest legal run
	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+design
design/sdrq_pkg.sv
design/sdrq_ram.sv
design/sdrq_ctrl.sv
design/sdrq_dp.sv
design/sorted_disk_request_queue.sv
design/sdrq_checker.sv
tb/sv/tb_sorted_disk_request_queue.sv
